>>> hw/rtl/pes_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pes_pkg: shared definitions of the particle Euler step
// Fixed-point constants, register indexes, the result record and helpers.
// ---------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] REG_GRAVITY_ON = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DRAG_ON    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WIND_ON    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STEP_TIME  = 3'd3;

  localparam logic [15:0] STEP_TIME_RESET = 16'd1092;

  // Q16.16 constants: gravity 9.8, drag 0.369*pi, wind 0.369*pi*25.
  localparam logic [19:0] GRAVITY_Q16 = 20'd642253;
  localparam logic [16:0] DRAG_K_Q16  = 17'd75972;
  localparam logic [20:0] WIND_W_Q16  = 21'd1899311;

  localparam int unsigned SqrtStages = 32;

  // Result fields that ride along the square-root pipeline.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [7:0]       life;
    logic             dead;
  } pes_res_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] x);
    logic [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    logic [31:0] r;
    r = x[31] ? (~x + 32'd1) : x;
    return r;
  endfunction

endpackage

>>> hw/rtl/pes_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pes_isqrt: pipelined integer square root
// One result bit per stage, 32 stages; carries the result record along.
// ---------------------------------------------------------------------------
module pes_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [63:0]       sq_i,
  input  pes_pkg::pes_res_t res_i,
  output logic              valid_o,
  output logic [30:0]       speed_o,
  output pes_pkg::pes_res_t res_o
);
  import pes_pkg::*;

  logic [SqrtStages-1:0] vld_q;
  logic [34:0]           rem_q [SqrtStages];
  logic [31:0]           root_q[SqrtStages];
  logic [63:0]           n_q   [SqrtStages];
  pes_res_t              res_q [SqrtStages];

  logic [34:0]           rem_d [SqrtStages];
  logic [31:0]           root_d[SqrtStages];
  logic [63:0]           n_d   [SqrtStages];

  always_comb begin
    for (int k = 0; k < SqrtStages; k++) begin
      logic [34:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] n_p;
      logic [34:0] r;
      logic [34:0] trial;
      if (k == 0) begin
        rem_p  = '0;
        root_p = '0;
        n_p    = sq_i;
      end else begin
        rem_p  = rem_q[k-1];
        root_p = root_q[k-1];
        n_p    = n_q[k-1];
      end
      r     = {rem_p[32:0], n_p[63:62]};
      trial = {1'b0, root_p, 2'b01};
      if (r >= trial) begin
        rem_d[k]  = r - trial;
        root_d[k] = {root_p[30:0], 1'b1};
      end else begin
        rem_d[k]  = r;
        root_d[k] = {root_p[30:0], 1'b0};
      end
      n_d[k] = {n_p[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[SqrtStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < SqrtStages; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        n_q[k]    <= n_d[k];
        res_q[k]  <= (k == 0) ? res_i : res_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign speed_o = root_q[SqrtStages-1][31] ? 31'h7FFF_FFFF : root_q[SqrtStages-1][30:0];
  assign res_o   = res_q[SqrtStages-1];

endmodule

>>> hw/rtl/particle_euler_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_euler_step: one explicit Euler step of a particle record
// Gravity, quadratic drag and a gusting wind push, signed Q16.16 saturated.
// ---------------------------------------------------------------------------
// The block takes one particle item per clock while its output is not
// stalled, and returns one result item per input item, in order. Ten
// arithmetic stages (size squared, drag and wind coefficients, drag force,
// force sum, velocity update, position update and squared length) precede
// a 32-stage square-root pipeline that resolves one speed bit per stage; its
// last stage is the output register. The whole pipeline advances whenever
// the output register is empty or being taken, so the sustained rate is one
// item per cycle and a stalled output holds every stage in place.
// Configuration registers may be written only while no item is in flight.
module particle_euler_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pes_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pes_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           pos_x_i,
  input  logic signed [31:0]           pos_y_i,
  input  logic signed [31:0]           pos_z_i,
  input  logic signed [31:0]           vel_x_i,
  input  logic signed [31:0]           vel_y_i,
  input  logic signed [31:0]           vel_z_i,
  input  logic [30:0]                  speed_in_i,
  input  logic [19:0]                  size_i,
  input  logic [7:0]                   life_in_i,
  input  logic                         gust_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           new_pos_x_o,
  output logic signed [31:0]           new_pos_y_o,
  output logic signed [31:0]           new_pos_z_o,
  output logic signed [31:0]           new_vel_x_o,
  output logic signed [31:0]           new_vel_y_o,
  output logic signed [31:0]           new_vel_z_o,
  output logic [30:0]                  speed_out_o,
  output logic [7:0]                   life_out_o,
  output logic                         dead_o
);
  import pes_pkg::*;

  // Configuration registers.
  logic        gravity_on_q, drag_on_q, wind_on_q;
  logic [15:0] step_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_on_q <= 1'b0;
      drag_on_q    <= 1'b0;
      wind_on_q    <= 1'b0;
      step_time_q  <= STEP_TIME_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRAVITY_ON: gravity_on_q <= cfg_wdata_i[0];
        REG_DRAG_ON:    drag_on_q    <= cfg_wdata_i[0];
        REG_WIND_ON:    wind_on_q    <= cfg_wdata_i[0];
        REG_STEP_TIME:  step_time_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one: every stage shifts when the output register
  // is free or its item is taken in this cycle.
  logic adv;
  logic sq_valid;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage valid bits for the ten arithmetic stages.
  logic [9:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[8:0], in_valid_i};
    end
  end

  // Input record carried through stages one to nine.
  logic [2:0][31:0] pos_q [9];
  logic [2:0][31:0] vel_q [9];
  logic [30:0]      spd_q [9];
  logic [7:0]       life_q[9];
  logic             gust_q[9];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_q[0]  <= {pos_z_i, pos_y_i, pos_x_i};
      vel_q[0]  <= {vel_z_i, vel_y_i, vel_x_i};
      spd_q[0]  <= speed_in_i;
      life_q[0] <= life_in_i;
      gust_q[0] <= gust_i;
      for (int k = 1; k < 9; k++) begin
        pos_q[k]  <= pos_q[k-1];
        vel_q[k]  <= vel_q[k-1];
        spd_q[k]  <= spd_q[k-1];
        life_q[k] <= life_q[k-1];
        gust_q[k] <= gust_q[k-1];
      end
    end
  end

  // Arithmetic stage registers.
  logic [23:0]      s2_q;
  logic [24:0]      dk_q;
  logic [28:0]      wind1_q, wind2_q, wind3_q;
  logic [30:0]      c_q;
  logic [2:0][46:0] dragm_q;
  logic [2:0][31:0] acc_q;
  logic [2:0][31:0] am_q;
  logic [2:0]       aneg_q;
  logic [2:0][31:0] nv7_q, nv8_q, nv9_q;
  logic [2:0][31:0] pm_q;
  logic [2:0]       pneg_q;
  logic [2:0][31:0] np_q;
  logic [2:0][63:0] sqm_q;
  logic [63:0]      sq_q;
  pes_res_t         res_q;

  logic [39:0] s2_prod;
  logic [40:0] dk_prod;
  logic [44:0] wind_prod;
  logic [55:0] c_prod;
  assign s2_prod   = 40'(size_i) * 40'(size_i);
  assign dk_prod   = 41'(DRAG_K_Q16) * 41'(s2_q);
  assign wind_prod = 45'(WIND_W_Q16) * 45'(s2_q);
  assign c_prod    = 56'(dk_q) * 56'(spd_q[1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: size squared.
      s2_q <= s2_prod[39:16];
      // Stage 2: drag and wind coefficients.
      dk_q    <= dk_prod[40:16];
      wind1_q <= wind_prod[44:16];
      // Stage 3: drag coefficient times the stored speed, saturated.
      c_q     <= (|c_prod[55:47]) ? 31'h7FFF_FFFF : c_prod[46:16];
      wind2_q <= wind1_q;
      wind3_q <= wind2_q;
      for (int i = 0; i < 3; i++) begin
        logic [62:0]        dprod;
        logic signed [49:0] f;
        logic [47:0]        aprod;
        logic signed [49:0] vsum;
        logic [47:0]        pprod;
        logic signed [49:0] psum;
        logic [31:0]        vm;
        // Stage 4: drag force magnitude.
        dprod      = 63'(c_q) * 63'(abs32(vel_q[2][i]));
        dragm_q[i] <= dprod[62:16];
        // Stage 5: net force, saturated to the acceleration.
        f = '0;
        if (drag_on_q) begin
          f = vel_q[3][i][31] ? $signed({3'b000, dragm_q[i]})
                              : -$signed({3'b000, dragm_q[i]});
        end
        if (i == 1 && gravity_on_q) begin
          f = f - $signed({30'd0, GRAVITY_Q16});
        end
        if (i == 0 && wind_on_q && gust_q[3]) begin
          f = f - $signed({21'd0, wind3_q});
        end
        acc_q[i] <= sat32(f);
        // Stage 6: acceleration times the step.
        aprod     = 48'(abs32(acc_q[i])) * 48'(step_time_q);
        am_q[i]   <= aprod[47:16];
        aneg_q[i] <= acc_q[i][31];
        // Stage 7: new velocity.
        vsum = 50'($signed(vel_q[5][i]));
        vsum = aneg_q[i] ? vsum - $signed({18'd0, am_q[i]})
                         : vsum + $signed({18'd0, am_q[i]});
        nv7_q[i] <= sat32(vsum);
        // Stage 8: velocity times the step.
        pprod     = 48'(abs32(nv7_q[i])) * 48'(step_time_q);
        pm_q[i]   <= pprod[47:16];
        pneg_q[i] <= nv7_q[i][31];
        nv8_q[i]  <= nv7_q[i];
        // Stage 9: new position and squared velocity components.
        psum = 50'($signed(pos_q[7][i]));
        psum = pneg_q[i] ? psum - $signed({18'd0, pm_q[i]})
                         : psum + $signed({18'd0, pm_q[i]});
        np_q[i]  <= sat32(psum);
        vm       = abs32(nv8_q[i]);
        sqm_q[i] <= 64'(vm) * 64'(vm);
        nv9_q[i] <= nv8_q[i];
      end
      // Stage 10: squared length and the result record.
      sq_q      <= sqm_q[0] + sqm_q[1] + sqm_q[2];
      res_q.pos  <= np_q;
      res_q.vel  <= nv9_q;
      res_q.life <= (life_q[8] == 8'd0) ? 8'd0 : life_q[8] - 8'd1;
      res_q.dead <= (life_q[8] == 8'd0);
    end
  end

  pes_res_t res_out;

  pes_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sq_valid),
    .sq_i    (sq_q),
    .res_i   (res_q),
    .valid_o (out_valid_o),
    .speed_o (speed_out_o),
    .res_o   (res_out)
  );

  assign sq_valid    = vld_q[9];
  assign new_pos_x_o = res_out.pos[0];
  assign new_pos_y_o = res_out.pos[1];
  assign new_pos_z_o = res_out.pos[2];
  assign new_vel_x_o = res_out.vel[0];
  assign new_vel_y_o = res_out.vel[1];
  assign new_vel_z_o = res_out.vel[2];
  assign life_out_o  = res_out.life;
  assign dead_o      = res_out.dead;

endmodule

>>> hw/rtl/pes_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pes_checker: port-level checks of the particle Euler step
// Watches the handshakes and result fields; attached by bind.
// ---------------------------------------------------------------------------
module pes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] new_pos_x_o,
  input logic [31:0] new_vel_x_o,
  input logic [31:0] new_vel_y_o,
  input logic [31:0] new_vel_z_o,
  input logic [30:0] speed_out_o,
  input logic [7:0]  life_out_o,
  input logic        dead_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_pos_x_o)
      && $stable(speed_out_o))
    else $error("result item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_dead_life: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dead_o |-> life_out_o == 8'd0)
    else $error("dead item with nonzero lifetime");

  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_vel_x_o == 32'd0 && new_vel_y_o == 32'd0
      && new_vel_z_o == 32'd0 |-> speed_out_o == 31'd0)
    else $error("nonzero speed for zero velocity");

endmodule

bind particle_euler_step pes_checker u_pes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .new_pos_x_o (new_pos_x_o),
  .new_vel_x_o (new_vel_x_o),
  .new_vel_y_o (new_vel_y_o),
  .new_vel_z_o (new_vel_z_o),
  .speed_out_o (speed_out_o),
  .life_out_o  (life_out_o),
  .dead_o      (dead_o)
);

>>> tb/particle_euler_step_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_euler_step_tb: self-checking bench for the particle Euler step
// Streams particle items through the block under several register settings,
// predicts each result in fixed point and compares it field by field.
// ---------------------------------------------------------------------------
module particle_euler_step_tb;
  import pes_pkg::*;

  // Quiet cycles at the end of each phase that drain the pipeline.
  localparam int unsigned DrainCycles = 60;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned HangLimit   = 4000;
  localparam int unsigned PhaseItems  = 320;

  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [30:0] speed;
    logic [19:0] size;
    logic [7:0]  life;
    logic        gust;
  } particle_t;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [30:0] speed;
    logic [7:0]  life;
    logic        dead;
  } step_res_t;

  // Products of Q16.16 values, truncated toward zero with the sign applied last.
  function automatic longint q16_mul(longint a, longint b);
    longint unsigned ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p  = (ua * ub) >> 16;
    return (((a < 0) != (b < 0)) ? -longint'(p) : longint'(p));
  endfunction

  function automatic longint clamp32(longint x);
    return (x > SatMax) ? SatMax : ((x < SatMin) ? SatMin : x);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  class step_scoreboard;
    bit              gravity_on, drag_on, wind_on;
    logic [15:0]     step_time;
    step_res_t       pending [$];
    int unsigned     errors, checked;

    function new();
      gravity_on = 0;
      drag_on    = 0;
      wind_on    = 0;
      step_time  = STEP_TIME_RESET;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_GRAVITY_ON: gravity_on = data[0];
        REG_DRAG_ON:    drag_on    = data[0];
        REG_WIND_ON:    wind_on    = data[0];
        REG_STEP_TIME:  step_time  = data[15:0];
        default: ;
      endcase
    endfunction

    // Work out the stepped particle and queue it as the next expected result.
    function void note_item(particle_t p);
      longint          net_f [3];
      longint          nv, np, vel, dt, s2, d, c, acc;
      longint unsigned sq, m, sp;
      step_res_t       r;
      dt = step_time;
      s2 = (longint'(p.size) * longint'(p.size)) >> 16;
      sq = 0;
      for (int i = 0; i < 3; i++) net_f[i] = 0;
      if (gravity_on) net_f[1] -= 642253;
      if (drag_on) begin
        d = (75972 * s2) >> 16;
        c = (d * longint'(p.speed)) >> 16;
        if (c > SatMax) c = SatMax;
        for (int i = 0; i < 3; i++) net_f[i] -= q16_mul(c, longint'($signed(p.vel[i])));
      end
      if (wind_on && p.gust) net_f[0] -= (1899311 * s2) >> 16;
      for (int i = 0; i < 3; i++) begin
        vel = longint'($signed(p.vel[i]));
        acc = clamp32(net_f[i]);
        nv  = clamp32(vel + q16_mul(acc, dt));
        np  = clamp32(longint'($signed(p.pos[i])) + q16_mul(nv, dt));
        m   = (nv < 0) ? -nv : nv;
        sq += m * m;
        r.vel[i] = nv[31:0];
        r.pos[i] = np[31:0];
      end
      sp = int_sqrt(sq);
      if (sp > 64'h7FFF_FFFF) sp = 64'h7FFF_FFFF;
      r.speed = sp[30:0];
      r.life  = (p.life == 0) ? 8'd0 : p.life - 8'd1;
      r.dead  = (p.life == 0);
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      end
    endfunction

    function void check_result(step_res_t a);
      step_res_t e;
      if (pending.size() == 0) begin
        errors++;
        $error("result item arrived with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("new_pos_x", e.pos[0], a.pos[0]);
      cmp("new_pos_y", e.pos[1], a.pos[1]);
      cmp("new_pos_z", e.pos[2], a.pos[2]);
      cmp("new_vel_x", e.vel[0], a.vel[0]);
      cmp("new_vel_y", e.vel[1], a.vel[1]);
      cmp("new_vel_z", e.vel[2], a.vel[2]);
      cmp("speed_out", 32'(e.speed), 32'(a.speed));
      cmp("life_out", 32'(e.life), 32'(a.life));
      cmp("dead", 32'(e.dead), 32'(a.dead));
    endfunction
  endclass

  logic                clk_i, rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i, in_ready_o;
  logic signed [31:0]  pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i;
  logic [30:0]         speed_in_i;
  logic [19:0]         size_i;
  logic [7:0]          life_in_i;
  logic                gust_i;
  logic                out_valid_o, out_ready_i;
  logic signed [31:0]  new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic signed [31:0]  new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic [30:0]         speed_out_o;
  logic [7:0]          life_out_o;
  logic                dead_o;

  particle_euler_step u_top (.*);

  step_scoreboard motion_sb;
  int unsigned    quiet_cycles = 0;
  int unsigned    sent_items;
  int unsigned    stall_mode;
  bit             hung = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both monitors sample at the rising edge, before the block updates anything.
  always @(posedge clk_i) begin
    particle_t p;
    step_res_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      p.pos[0] = pos_x_i;  p.pos[1] = pos_y_i;  p.pos[2] = pos_z_i;
      p.vel[0] = vel_x_i;  p.vel[1] = vel_y_i;  p.vel[2] = vel_z_i;
      p.speed  = speed_in_i;
      p.size   = size_i;
      p.life   = life_in_i;
      p.gust   = gust_i;
      motion_sb.note_item(p);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.pos[0] = new_pos_x_o;  r.pos[1] = new_pos_y_o;  r.pos[2] = new_pos_z_o;
      r.vel[0] = new_vel_x_o;  r.vel[1] = new_vel_y_o;  r.vel[2] = new_vel_z_o;
      r.speed  = speed_out_o;
      r.life   = life_out_o;
      r.dead   = dead_o;
      motion_sb.check_result(r);
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit && !hung) begin
      hung = 1'b1;
      $display("particle_euler_step verification failed");
      $finish;
    end
  end

  // The receiver stalls on its own pattern, chosen per phase: always ready,
  // random with a light or heavy duty cycle, or long periodic stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = ($urandom_range(0, 9) < 8);
        2: out_ready_i = ($urandom_range(0, 9) < 3);
        default: out_ready_i = (($time / 10) % 23) < 15;
      endcase
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    motion_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Present one item and hold it until the block takes it. Valid stays high
  // into the next item unless a gap follows.
  task automatic send_item(particle_t p);
    @(negedge clk_i);
    pos_x_i = p.pos[0];  pos_y_i = p.pos[1];  pos_z_i = p.pos[2];
    vel_x_i = p.vel[0];  vel_y_i = p.vel[1];  vel_z_i = p.vel[2];
    speed_in_i = p.speed;
    size_i     = p.size;
    life_in_i  = p.life;
    gust_i     = p.gust;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
  endtask

  task automatic idle_gap(int unsigned n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Mostly moderate magnitudes so that drag and gravity stay visible;
  // the rest uses full-range bit patterns that drive saturation.
  function automatic particle_t rand_particle();
    particle_t p;
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = wide ? $urandom : 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      p.vel[i] = wide ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    end
    p.speed = wide ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
    p.size  = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 1 << 17));
    p.life  = 8'($urandom);
    p.gust  = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic particle_t make_particle(logic [31:0] pv, logic [31:0] vv,
                                              logic [30:0] sp, logic [19:0] sz,
                                              logic [7:0] lf, logic g);
    particle_t p;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = pv;
      p.vel[i] = vv;
    end
    p.speed = sp;  p.size = sz;  p.life = lf;  p.gust = g;
    return p;
  endfunction

  // Directed corners: field extremes, zero velocity under drag, a drag
  // coefficient big enough to saturate, lifetime at zero, one and full.
  task automatic send_corners();
    particle_t p;
    send_item(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 20'hFFFFF, 8'd255, 1'b1));
    send_item(make_particle(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 20'hFFFFF, 8'd0, 1'b1));
    send_item(make_particle(32'h0, 32'h0, 31'h0, 20'h0, 8'd1, 1'b0));
    send_item(make_particle(32'h0001_0000, 32'h0, 31'h0004_0000, 20'h1_0000, 8'd0, 1'b1));
    send_item(make_particle(32'hFFFF_0000, 32'h0002_0000, 31'h7FFF_FFFF, 20'hFFFFF, 8'd10, 1'b0));
    send_item(make_particle(32'h0, 32'hFFFE_0000, 31'h0002_0000, 20'h0_8000, 8'd2, 1'b1));
    send_item(make_particle(32'hFFFF_FFFF, 32'h0000_0001, 31'h1, 20'h1, 8'd128, 1'b0));
    p = make_particle(32'h7FFF_0000, 32'h0100_0000, 31'h0100_0000, 20'h2_0000, 8'd1, 1'b1);
    p.vel[1] = 32'hFF00_0000;
    p.vel[2] = 32'h0;
    send_item(p);
    p.pos[0] = 32'h8000_0001;
    p.vel[0] = 32'h8000_0000;
    p.vel[1] = 32'h7FFF_FFFF;
    p.life   = 8'd0;
    send_item(p);
  endtask

  task automatic run_phase(bit g, bit d, bit w, logic [15:0] dt, int unsigned mode);
    int unsigned burst;
    write_reg(REG_GRAVITY_ON, {15'($urandom), g});
    write_reg(REG_DRAG_ON, {15'($urandom), d});
    write_reg(REG_WIND_ON, {15'($urandom), w});
    write_reg(REG_STEP_TIME, dt);
    // Indexes past the last register must leave everything unchanged.
    write_reg(3'(4 + $urandom_range(0, 3)), 16'($urandom));
    stall_mode = mode;
    send_corners();
    for (int n = 0; n < PhaseItems; ) begin
      burst = (mode == 0 && n < 60) ? 60 : $urandom_range(1, 24);
      for (int k = 0; k < burst && n < PhaseItems; k++, n++) send_item(rand_particle());
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
    idle_gap(0);
    while (motion_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    motion_sb    = new();
    sent_items   = 0;
    stall_mode   = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    pos_x_i = '0;  pos_y_i = '0;  pos_z_i = '0;
    vel_x_i = '0;  vel_y_i = '0;  vel_z_i = '0;
    speed_in_i = '0;  size_i = '0;  life_in_i = '0;  gust_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values first: no forces, default step.
    stall_mode = 1;
    send_corners();
    for (int n = 0; n < 40; n++) send_item(rand_particle());
    idle_gap(0);
    while (motion_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    run_phase(1'b1, 1'b1, 1'b1, 16'hFFFF, 0);
    run_phase(1'b0, 1'b0, 1'b0, 16'h0000, 2);
    run_phase(1'b1, 1'b0, 1'b1, 16'h0001, 3);
    run_phase(1'b0, 1'b1, 1'b0, STEP_TIME_RESET, 1);
    run_phase(1'b1, 1'b1, 1'b1, 16'($urandom), 1);

    $display("Covered %0d particle items over six register settings (forces on and off,",
             sent_items);
    $display("step from 0 to full scale), %0d results checked.", motion_sb.checked);
    if (motion_sb.errors == 0 && motion_sb.pending.size() == 0) begin
      $display("particle_euler_step verification clean");
    end else begin
      $display("particle_euler_step verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pes_pkg.sv
hw/rtl/pes_isqrt.sv
hw/rtl/particle_euler_step.sv
hw/rtl/pes_checker.sv
tb/particle_euler_step_tb.sv
